@@ hw/rtl/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants of the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 6;
  localparam int DIGIT_W   = 4;
  localparam int MULT_W    = 34;
  localparam int IDX_W     = 4;
  localparam int NUM_MULTS = 9;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic [IDX_W-1:0]  LAST_IDX    = 4'd9;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [MULT_W-1:0] pow_mult(input logic [IDX_W-1:0] idx,
                                                 input logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] p;
    unique case (idx)
      4'd0:    p = 34'd1000000000;
      4'd1:    p = 34'd100000000;
      4'd2:    p = 34'd10000000;
      4'd3:    p = 34'd1000000;
      4'd4:    p = 34'd100000;
      4'd5:    p = 34'd10000;
      4'd6:    p = 34'd1000;
      4'd7:    p = 34'd100;
      4'd8:    p = 34'd10;
      default: p = 34'd1;
    endcase
    return MULT_W'(p * {{(MULT_W-DIGIT_W){1'b0}}, k});
  endfunction

endpackage

@@ hw/rtl/signed_int_to_decimal_ascii_unit.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer to its decimal ASCII characters.
//
//   channel | ports                             | dir
//   in      | in_valid in_stall in_value        | request in
//   out     | out_valid out_stall out_char_code | one character out
//           | out_last                          |
//
// a number passes a load step, then the digit steps; the minus sign leaves in the load step
// the engine handles one power of ten per cycle while out_stall does not hold it
// a two-entry queue lets the input stage take the next request meanwhile
// synchronous active-low reset clears all handshake state
// out_stall holds the engine; in_stall rises only when the queue is full
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                 out_last
);

  sitda_pkg::q_stat_t q_stat;
  sitda_pkg::item_t   push_item;
  sitda_pkg::item_t   pop_item;
  logic               push;
  logic               pop;

  sitda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  sitda_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  sitda_digits u_digits (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_item      (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

@@ hw/rtl/sitda_front.sv @@
// ----------------------------------------------------------------------------
// sitda_front
// Input stage: takes one request, splits it into sign and magnitude.
// ----------------------------------------------------------------------------
module sitda_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  input  sitda_pkg::q_stat_t             q_stat,
  output logic                           push,
  output sitda_pkg::item_t               push_item
);

  logic             valid_r;
  sitda_pkg::item_t item_r;
  logic [sitda_pkg::VALUE_W-1:0] raw;

  assign raw       = in_value;
  assign push      = valid_r && !q_stat.full;
  assign in_stall  = valid_r && q_stat.full;
  assign push_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (!valid_r || push) begin
        valid_r <= in_valid;
      end
    end
    if (in_valid && !in_stall) begin
      item_r.neg <= raw[sitda_pkg::VALUE_W-1];
      item_r.mag <= raw[sitda_pkg::VALUE_W-1] ? (~raw + 32'd1) : raw;
    end
  end

endmodule

@@ hw/rtl/sitda_fifo.sv @@
// ----------------------------------------------------------------------------
// sitda_fifo
// Short queue between the input stage and the digit engine.
// ----------------------------------------------------------------------------
module sitda_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sitda_pkg::item_t   push_item,
  input  logic               pop,
  output sitda_pkg::item_t   pop_item,
  output sitda_pkg::q_stat_t q_stat
);

  sitda_pkg::item_t             mem [sitda_pkg::Q_DEPTH];
  logic [sitda_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [sitda_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [sitda_pkg::Q_AW:0]     count_r;

  assign q_stat.full  = (count_r == (sitda_pkg::Q_AW+1)'(sitda_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_item     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (sitda_pkg::Q_AW+1)'(sitda_pkg::Q_DEPTH))
    else $error("queue count out of range");

endmodule

@@ hw/rtl/sitda_digits.sv @@
// ----------------------------------------------------------------------------
// sitda_digits
// Digit engine: one decimal digit per cycle while out_stall does not hold it, leading zeros dropped.
// ----------------------------------------------------------------------------
module sitda_digits (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sitda_pkg::q_stat_t              q_stat,
  input  sitda_pkg::item_t                pop_item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]    out_char_code,
  output logic                            out_last
);

  typedef enum logic {ST_IDLE, ST_DIGIT} state_t;

  state_t                          state_r;
  logic                            out_valid_r;
  logic [sitda_pkg::CHAR_W-1:0]    out_char_r;
  logic                            out_last_r;
  logic [sitda_pkg::VALUE_W-1:0]   mag_r;
  logic [sitda_pkg::IDX_W-1:0]     idx_r;
  logic                            started_r;

  logic                            advance;
  logic [sitda_pkg::MULT_W-1:0]    mult [1:sitda_pkg::NUM_MULTS];
  logic [sitda_pkg::NUM_MULTS-1:0] ge;
  logic [sitda_pkg::DIGIT_W-1:0]   digit;
  logic [sitda_pkg::VALUE_W-1:0]   rem_nxt;
  logic                            emit;
  logic                            last_step;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign advance       = !out_valid_r || !out_stall;
  assign pop           = (state_r == ST_IDLE) && !q_stat.empty && advance;
  assign last_step     = (idx_r == sitda_pkg::LAST_IDX);

  // parallel compare against all nine multiples of the current power
  always_comb begin
    for (int k = 1; k <= sitda_pkg::NUM_MULTS; k++) begin
      mult[k]  = sitda_pkg::pow_mult(idx_r, sitda_pkg::DIGIT_W'(k));
      ge[k-1]  = ({2'b00, mag_r} >= mult[k]);
    end
    digit   = sitda_pkg::DIGIT_W'($countones(ge));
    rem_nxt = mag_r;
    if (digit != '0) begin
      rem_nxt = mag_r - mult[digit][sitda_pkg::VALUE_W-1:0];
    end
    emit = (digit != '0) || started_r || last_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      started_r   <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state_r   <= ST_DIGIT;
            mag_r     <= pop_item.mag;
            idx_r     <= '0;
            started_r <= 1'b0;
            if (pop_item.neg) begin
              out_valid_r <= 1'b1;
              out_char_r  <= sitda_pkg::ASCII_MINUS;
              out_last_r  <= 1'b0;
            end
          end
        end
        ST_DIGIT: begin
          mag_r     <= rem_nxt;
          started_r <= started_r || emit;
          if (emit) begin
            out_valid_r <= 1'b1;
            out_char_r  <= sitda_pkg::ASCII_ZERO + {2'b00, digit};
            out_last_r  <= last_step;
          end
          if (last_step) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_char_r != sitda_pkg::ASCII_MINUS)
    else $error("last mark on minus sign");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIGIT |-> idx_r <= sitda_pkg::LAST_IDX)
    else $error("digit index out of range");

  a_final_digit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIGIT && last_step && advance |=>
      state_r == ST_IDLE && out_valid_r && out_last_r)
    else $error("final digit not marked");

endmodule
